FILE: rtl/pressure_temp_calib_interp_defines.svh
// Assertion macros shared by the calibration engine RTL.
`ifndef PRESSURE_TEMP_CALIB_INTERP_DEFINES_SVH
`define PRESSURE_TEMP_CALIB_INTERP_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define PTCI_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define PTCI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ptci_pkg.sv
`default_nettype none
package ptci_pkg;
   localparam int MAX_ROWS       = 3;
   localparam int POINTS_PER_ROW = 8;
   localparam int DEPTH          = MAX_ROWS * POINTS_PER_ROW;
   localparam int ADDR_W         = $clog2(DEPTH);
   localparam int RIDX_W         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SEG_W          = $clog2(POINTS_PER_ROW);
   localparam int RC_W           = 2;
   localparam int PC_W           = 4;
   localparam int P_W            = 32;
   localparam int ADC_W          = 16;
   localparam int ENTRY_W        = P_W + 2 * ADC_W;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 4;
   localparam int DVD_W          = P_W + 1;
   localparam int DVS_W          = ADC_W + 1;
   localparam int QUO_W          = DVD_W + 1;
   localparam int OFF_W          = ADC_W + 1;
   localparam int PROD_W         = QUO_W + OFF_W;
   localparam int SUM_W          = PROD_W + 1;
   localparam int DCNT_W         = $clog2(DVD_W);

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE = 1'd1;
   localparam logic                 ACT_STORE         = 1'b0;
   localparam logic                 ACT_COMPUTE       = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [1:0]              row_index;
      logic [2:0]              column_index;
      logic signed [P_W-1:0]   point_pressure;
      logic signed [ADC_W-1:0] point_pressure_adc;
      logic signed [ADC_W-1:0] point_temp_adc;
      logic signed [ADC_W-1:0] measured_pressure_adc;
      logic signed [ADC_W-1:0] measured_temp_adc;
   } req_type;

   typedef struct packed {
      logic signed [P_W-1:0] pressure;
      logic                  saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [P_W-1:0]   press;
      logic signed [ADC_W-1:0] padc;
      logic signed [ADC_W-1:0] tadc;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_LO, S_HI, S_PREP, S_DIV, S_MUL, S_ADD, S_TEMP, S_OUT
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/ptci_ram.sv
`default_nettype none
module ptci_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/ptci_div.sv
`default_nettype none
module ptci_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [ptci_pkg::DVD_W-1:0]   dividend,
   input  wire logic signed [ptci_pkg::DVS_W-1:0]   divisor,
   output logic                                     done_ff,
   output logic signed      [ptci_pkg::QUO_W-1:0]   quotient_ff
);
   localparam int DW = ptci_pkg::DVD_W;
   localparam int SW = ptci_pkg::DVS_W;
   localparam int QW = ptci_pkg::QUO_W;
   localparam int CW = ptci_pkg::DCNT_W;

   logic              busy_ff, busy_in, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     num_ff, num_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [SW-1:0]     den_ff, den_in;
   logic              neg_ff, neg_in;
   logic signed [QW-1:0] quotient_in;
   logic [SW:0]       shifted;
   logic [SW+1:0]     diff;
   logic              qbit;
   logic [DW-1:0]     num_step;

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      quotient_in = quotient_ff;
      shifted     = {rem_ff, num_ff[DW-1]};
      diff        = {1'b0, shifted} - {2'b0, den_ff};
      qbit        = !diff[SW+1];
      num_step    = {num_ff[DW-2:0], qbit};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[DW-1] ^ divisor[SW-1];
         num_in  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         den_in  = divisor[SW-1] ? SW'(-divisor) : SW'(divisor);
      end else if (busy_ff) begin
         num_in = num_step;
         rem_in = qbit ? diff[SW-1:0] : shifted[SW-1:0];
         cnt_in = CW'(cnt_ff + CW'(1));
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in     = 1'b0;
            done_in     = 1'b1;
            quotient_in = neg_ff ? -QW'({1'b0, num_step}) : QW'({1'b0, num_step});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      quotient_ff <= quotient_in;
   end
endmodule
`default_nettype wire

FILE: rtl/pressure_temp_calib_interp.sv
// Pressure calibration engine with two-dimensional piecewise-linear lookup.
// Request channel (req_valid, req_stall, req_data): a store request writes one
// calibration point, out-of-range row or column is dropped; a compute request
// converts a pressure and a temperature ADC reading into one response.
// Response channel (rsp_valid, rsp_stall, rsp_data): one response per compute,
// none per store. Registers (csr_we, csr_index, csr_wdata) are to be written by
// the user only while idle; the block itself does not enforce this. A compute
// walks each row in use through the table RAM (one point per cycle), then runs
// a 33-step shift-subtract division and one multiply; the division is skipped
// when the segment has equal ADC values. With more than one row in use, a
// further pass interpolates across the row results in the same way.
// One request is in flight at a time; req_stall is high while busy.
// The response sits in an output register; a stalled response holds, and a
// finished compute waits for that register before returning to idle.
// Reset clears control state and sets row_count to 3 and points_in_use to 8;
// the table content is undefined until written.
`default_nettype none
`include "pressure_temp_calib_interp_defines.svh"
module pressure_temp_calib_interp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ptci_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ptci_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [ptci_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ptci_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int AW  = ptci_pkg::ADDR_W;
   localparam int RW  = ptci_pkg::RIDX_W;
   localparam int SGW = ptci_pkg::SEG_W;
   localparam int RCW = ptci_pkg::RC_W;
   localparam int PCW = ptci_pkg::PC_W;
   localparam int PW  = ptci_pkg::P_W;
   localparam int AD  = ptci_pkg::ADC_W;
   localparam int SUW = ptci_pkg::SUM_W;
   localparam int PRW = ptci_pkg::PROD_W;
   localparam int OW  = ptci_pkg::OFF_W;
   localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

   ptci_pkg::state_type state_ff, state_in;
   logic [RCW-1:0] row_count_ff, row_count_in;
   logic [PCW-1:0] points_ff, points_in;
   logic [RCW-1:0] rows_eff;
   logic [PCW-1:0] pts_eff;

   logic [RW-1:0]  row_ff, row_in;
   logic [SGW-1:0] seg_ff, seg_in;
   ptci_pkg::entry_type lo_ff, lo_in, rd_entry;
   logic signed [AD-1:0] rowt_ff, rowt_in;
   logic signed [AD-1:0] xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic signed [PW-1:0] ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic                 pass_ff, pass_in;
   logic signed [OW-1:0] off_ff, off_in;
   logic signed [ptci_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [AD-1:0] qp_ff, qp_in, qt_ff, qt_in;
   logic signed [AD-1:0] tlo_t_ff, tlo_t_in, thi_t_ff, thi_t_in;
   logic signed [PW-1:0] tlo_p_ff, tlo_p_in, thi_p_ff, thi_p_in;
   logic                 tfound_ff, tfound_in;
   logic                 clip_ff, clip_in;
   logic signed [PW-1:0] res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ptci_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [ptci_pkg::ENTRY_W-1:0] rd_data;
   ptci_pkg::entry_type  wr_entry;
   logic                 div_start, div_done;
   logic signed [ptci_pkg::DVD_W-1:0] dy;
   logic signed [ptci_pkg::DVS_W-1:0] dx;
   logic signed [ptci_pkg::QUO_W-1:0] div_quo;
   logic signed [SUW-1:0] sum;
   logic signed [PW-1:0]  val;
   logic                  val_clip;
   logic                  seg_stop, tstop;
   logic signed [AD-1:0]  q_sel;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [SGW-1:0] c);
      addr_of = AW'(AW'(r) * AW'(ptci_pkg::POINTS_PER_ROW) + AW'(c));
   endfunction

   assign rows_eff = (row_count_ff == '0) ? RCW'(1) :
                     ((row_count_ff > RCW'(ptci_pkg::MAX_ROWS)) ? RCW'(ptci_pkg::MAX_ROWS)
                                                                  : row_count_ff);
   assign pts_eff  = (points_ff < PCW'(2)) ? PCW'(2) :
                     ((points_ff > PCW'(ptci_pkg::POINTS_PER_ROW))
                        ? PCW'(ptci_pkg::POINTS_PER_ROW) : points_ff);

   assign rd_entry  = ptci_pkg::entry_type'(rd_data);
   assign req_stall = (state_ff != ptci_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ptci_ram #(.WIDTH(ptci_pkg::ENTRY_W), .DEPTH(ptci_pkg::DEPTH)) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_entry),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   ptci_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (dy),
      .divisor     (dx),
      .done_ff     (div_done),
      .quotient_ff (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      points_in    = points_ff;
      row_in       = row_ff;
      seg_in       = seg_ff;
      lo_in        = lo_ff;
      rowt_in      = rowt_ff;
      xlo_in       = xlo_ff;
      xhi_in       = xhi_ff;
      ylo_in       = ylo_ff;
      yhi_in       = yhi_ff;
      pass_in      = pass_ff;
      off_in       = off_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      qp_in        = qp_ff;
      qt_in        = qt_ff;
      tlo_t_in     = tlo_t_ff;
      tlo_p_in     = tlo_p_ff;
      thi_t_in     = thi_t_ff;
      thi_p_in     = thi_p_ff;
      tfound_in    = tfound_ff;
      clip_in      = clip_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_of(RW'(req_data.row_index), SGW'(req_data.column_index));
      wr_entry.press = req_data.point_pressure;
      wr_entry.padc  = req_data.point_pressure_adc;
      wr_entry.tadc  = req_data.point_temp_adc;
      rd_addr      = addr_of(row_ff, seg_ff);
      div_start    = 1'b0;
      q_sel        = pass_ff ? qt_ff : qp_ff;
      dy           = ptci_pkg::DVD_W'(yhi_ff) - ptci_pkg::DVD_W'(ylo_ff);
      dx           = ptci_pkg::DVS_W'(xhi_ff) - ptci_pkg::DVS_W'(xlo_ff);
      sum          = SUW'(ylo_ff) + SUW'(prod_ff);
      val_clip     = (sum > SUW'(P_MAX)) || (sum < SUW'(P_MIN));
      val          = (sum > SUW'(P_MAX)) ? P_MAX :
                     ((sum < SUW'(P_MIN)) ? P_MIN : PW'(sum));
      seg_stop     = (PCW'(seg_ff) + PCW'(2) >= pts_eff) ||
                     ((lo_ff.padc < rd_entry.padc) ? (qp_ff < rd_entry.padc)
                                                   : (qp_ff >= rd_entry.padc));
      tstop        = (RCW'(row_ff) + RCW'(1) >= rows_eff) ||
                     ((tlo_t_ff < rowt_ff) ? (qt_ff < rowt_ff) : (qt_ff >= rowt_ff));

      if (csr_we) begin
         case (csr_index)
            ptci_pkg::CSR_ROW_COUNT:     row_count_in = RCW'(csr_wdata);
            ptci_pkg::CSR_POINTS_IN_USE: points_in    = PCW'(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ptci_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ptci_pkg::ACT_STORE) begin
                  wr_en = (RCW'(req_data.row_index) < rows_eff) &&
                          (PCW'(req_data.column_index) < pts_eff);
               end else begin
                  qp_in     = req_data.measured_pressure_adc;
                  qt_in     = req_data.measured_temp_adc;
                  row_in    = '0;
                  seg_in    = '0;
                  pass_in   = 1'b0;
                  tfound_in = 1'b0;
                  clip_in   = 1'b0;
                  rd_addr   = addr_of('0, '0);
                  state_in  = ptci_pkg::S_LO;
               end
            end
         end
         ptci_pkg::S_LO: begin
            lo_in    = rd_entry;
            rowt_in  = rd_entry.tadc;
            rd_addr  = addr_of(row_ff, SGW'(seg_ff + SGW'(1)));
            state_in = ptci_pkg::S_HI;
         end
         ptci_pkg::S_HI: begin
            if (seg_stop) begin
               xlo_in   = lo_ff.padc;
               xhi_in   = rd_entry.padc;
               ylo_in   = lo_ff.press;
               yhi_in   = rd_entry.press;
               state_in = ptci_pkg::S_PREP;
            end else begin
               lo_in   = rd_entry;
               seg_in  = SGW'(seg_ff + SGW'(1));
               rd_addr = addr_of(row_ff, SGW'(seg_ff + SGW'(2)));
            end
         end
         ptci_pkg::S_PREP: begin
            off_in = OW'(q_sel) - OW'(xlo_ff);
            if (dx == '0) begin
               prod_in  = '0;
               state_in = ptci_pkg::S_ADD;
            end else begin
               div_start = 1'b1;
               state_in  = ptci_pkg::S_DIV;
            end
         end
         ptci_pkg::S_DIV: begin
            if (div_done) begin
               quo_in   = div_quo;
               state_in = ptci_pkg::S_MUL;
            end
         end
         ptci_pkg::S_MUL: begin
            prod_in  = PRW'(quo_ff) * PRW'(off_ff);
            state_in = ptci_pkg::S_ADD;
         end
         ptci_pkg::S_ADD: begin
            clip_in = clip_ff | val_clip;
            if (pass_ff) begin
               res_in   = val;
               state_in = ptci_pkg::S_OUT;
            end else begin
               if (row_ff == '0) begin
                  tlo_t_in = rowt_ff;
                  tlo_p_in = val;
               end else if (!tfound_ff) begin
                  if (tstop) begin
                     thi_t_in  = rowt_ff;
                     thi_p_in  = val;
                     tfound_in = 1'b1;
                  end else begin
                     tlo_t_in = rowt_ff;
                     tlo_p_in = val;
                  end
               end
               if (RCW'(row_ff) + RCW'(1) < rows_eff) begin
                  row_in   = RW'(row_ff + RW'(1));
                  seg_in   = '0;
                  rd_addr  = addr_of(RW'(row_ff + RW'(1)), '0);
                  state_in = ptci_pkg::S_LO;
               end else if (rows_eff == RCW'(1)) begin
                  res_in   = val;
                  state_in = ptci_pkg::S_OUT;
               end else begin
                  state_in = ptci_pkg::S_TEMP;
               end
            end
         end
         ptci_pkg::S_TEMP: begin
            xlo_in   = tlo_t_ff;
            xhi_in   = thi_t_ff;
            ylo_in   = tlo_p_ff;
            yhi_in   = thi_p_ff;
            pass_in  = 1'b1;
            state_in = ptci_pkg::S_PREP;
         end
         ptci_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.pressure  = res_ff;
               rsp_data_in.saturated = clip_ff;
               state_in              = ptci_pkg::S_IDLE;
            end
         end
         default: state_in = ptci_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptci_pkg::S_IDLE;
         row_count_ff <= RCW'(3);
         points_ff    <= PCW'(8);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      seg_ff      <= seg_in;
      lo_ff       <= lo_in;
      rowt_ff     <= rowt_in;
      xlo_ff      <= xlo_in;
      xhi_ff      <= xhi_in;
      ylo_ff      <= ylo_in;
      yhi_ff      <= yhi_in;
      pass_ff     <= pass_in;
      off_ff      <= off_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      qp_ff       <= qp_in;
      qt_ff       <= qt_in;
      tlo_t_ff    <= tlo_t_in;
      tlo_p_ff    <= tlo_p_in;
      thi_t_ff    <= thi_t_in;
      thi_p_ff    <= thi_p_in;
      tfound_ff   <= tfound_in;
      clip_ff     <= clip_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PTCI_ASSERT_HOLDS(a_div_done_in_div, clock, reset,
      !div_done || state_ff == ptci_pkg::S_DIV, "divider finished outside wait state")
   `PTCI_ASSERT_NEXT(a_out_loads, clock, reset,
      state_ff == ptci_pkg::S_OUT && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == ptci_pkg::S_IDLE, "response not loaded")
   `PTCI_ASSERT_HOLDS(a_seg_in_row, clock, reset,
      state_ff != ptci_pkg::S_HI || (PCW'(seg_ff) + PCW'(1) < pts_eff),
      "segment search past last point")
endmodule
`default_nettype wire

FILE: dv/pressure_temp_calib_interp_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module pressure_temp_calib_interp_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ptci_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ptci_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [ptci_pkg::CSR_IDX_W-1:0] csr_index = ptci_pkg::CSR_ROW_COUNT;
   logic [ptci_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pressure_temp_calib_interp dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // calibration table and register copies
   longint pt_press [ptci_pkg::DEPTH];
   longint cal_padc [ptci_pkg::DEPTH];
   longint cal_tadc [ptci_pkg::DEPTH];
   logic [1:0] rows_reg = 2'd3;
   logic [3:0] points_reg = 4'd8;

   ptci_pkg::rsp_type pending_pressures[$];
   int errors = 0;
   bit quiet = 1'b0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;

   function automatic longint clamp32(input longint v, inout bit clip);
      if (v > 64'sd2147483647) begin
         clip = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clip = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint segment_lookup(input longint xs[ptci_pkg::POINTS_PER_ROW],
         input longint ys[ptci_pkg::POINTS_PER_ROW], input int n, input longint q,
         inout bit clip);
      int i;
      longint dx, dy, r;
      for (i = 0; i + 2 < n; i++) begin
         if (xs[i] < xs[i+1]) begin
            if (q < xs[i+1]) break;
         end else begin
            if (q >= xs[i+1]) break;
         end
      end
      r = ys[i];
      dy = ys[i+1] - ys[i];
      dx = xs[i+1] - xs[i];
      if (dx != 0) r = r + (dy / dx) * (q - xs[i]);
      return clamp32(r, clip);
   endfunction

   function automatic int rows_used();
      return (rows_reg < 1) ? 1 : (rows_reg > ptci_pkg::MAX_ROWS) ? ptci_pkg::MAX_ROWS
            : int'(rows_reg);
   endfunction

   function automatic int points_used();
      return (points_reg < 2) ? 2 : (points_reg > ptci_pkg::POINTS_PER_ROW)
            ? ptci_pkg::POINTS_PER_ROW : int'(points_reg);
   endfunction

   task automatic predict_request(input ptci_pkg::req_type r);
      longint xs[ptci_pkg::POINTS_PER_ROW], ys[ptci_pkg::POINTS_PER_ROW];
      longint rt[ptci_pkg::POINTS_PER_ROW], rp[ptci_pkg::POINTS_PER_ROW];
      int rows, pts, k;
      bit clip;
      longint res;
      ptci_pkg::rsp_type e;
      rows = rows_used();
      pts = points_used();
      clip = 1'b0;
      if (r.action == ptci_pkg::ACT_STORE) begin
         if (r.row_index < rows && r.column_index < pts) begin
            k = r.row_index * ptci_pkg::POINTS_PER_ROW + r.column_index;
            pt_press[k] = longint'(r.point_pressure);
            cal_padc[k] = longint'(r.point_pressure_adc);
            cal_tadc[k] = longint'(r.point_temp_adc);
         end
      end else begin
         for (int i = 0; i < ptci_pkg::POINTS_PER_ROW; i++) begin
            rt[i] = 0;
            rp[i] = 0;
         end
         for (int rw = 0; rw < rows; rw++) begin
            for (int c = 0; c < ptci_pkg::POINTS_PER_ROW; c++) begin
               xs[c] = cal_padc[rw*ptci_pkg::POINTS_PER_ROW + c];
               ys[c] = pt_press[rw*ptci_pkg::POINTS_PER_ROW + c];
            end
            rp[rw] = segment_lookup(xs, ys, pts, longint'(r.measured_pressure_adc), clip);
            rt[rw] = cal_tadc[rw*ptci_pkg::POINTS_PER_ROW];
         end
         if (rows == 1) res = rp[0];
         else res = segment_lookup(rt, rp, rows, longint'(r.measured_temp_adc), clip);
         e.pressure = res[31:0];
         e.saturated = clip;
         pending_pressures.push_back(e);
      end
   endtask

   task automatic send_req(input ptci_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_request(r);
   endtask

   function automatic ptci_pkg::req_type noise_req();
      logic [127:0] bits;
      ptci_pkg::req_type r;
      bits = {$urandom, $urandom, $urandom, $urandom};
      r = bits[$bits(ptci_pkg::req_type)-1:0];
      return r;
   endfunction

   task automatic store_point(input int row, input int col, input longint p,
         input longint pa, input longint ta);
      ptci_pkg::req_type r;
      r = noise_req();
      r.action = ptci_pkg::ACT_STORE;
      r.row_index = row[1:0];
      r.column_index = col[2:0];
      r.point_pressure = p[31:0];
      r.point_pressure_adc = pa[15:0];
      r.point_temp_adc = ta[15:0];
      send_req(r);
   endtask

   task automatic convert(input longint qp, input longint qt);
      ptci_pkg::req_type r;
      r = noise_req();
      r.action = ptci_pkg::ACT_COMPUTE;
      r.measured_pressure_adc = qp[15:0];
      r.measured_temp_adc = qt[15:0];
      send_req(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pressures.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] rows, input logic [3:0] pts);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= ptci_pkg::CSR_ROW_COUNT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= ptci_pkg::CSR_POINTS_IN_USE;
      csr_wdata <= pts;
      @(posedge clock);
      csr_we <= 1'b0;
      rows_reg = rows[1:0];
      points_reg = pts;
   endtask

   // rows: ADC mostly monotonic (rising or falling) with random jumps, random spacing
   task automatic load_table(input int big);
      longint pa, ta, p, step, tstep;
      bit fall;
      ta = $urandom_range(0, 1) ? -32768 + longint'($urandom_range(0, 20000))
            : 32767 - longint'($urandom_range(0, 20000));
      tstep = (ta < 0) ? $urandom_range(0, 6000) : -longint'($urandom_range(0, 6000));
      for (int rw = 0; rw < ptci_pkg::MAX_ROWS; rw++) begin
         fall = $urandom_range(0, 1);
         pa = fall ? 32767 - longint'($urandom_range(0, 9000))
               : -32768 + longint'($urandom_range(0, 9000));
         p = big ? longint'($signed($urandom)) : longint'($urandom_range(0, 200000)) - 100000;
         for (int c = 0; c < ptci_pkg::POINTS_PER_ROW; c++) begin
            if ($urandom_range(9) == 0) pa = longint'($signed(16'($urandom)));
            store_point(rw, c, p, pa, ta + ($urandom_range(3) == 0 ? $urandom_range(0, 50) : 0));
            step = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 8000);
            pa = fall ? pa - step : pa + step;
            if (pa > 32767) pa = 32767;
            if (pa < -32768) pa = -32768;
            p = p + (big ? longint'($signed($urandom)) : longint'($urandom_range(0, 40000)) - 20000);
            if (p > 64'sd2147483647 || p < -64'sd2147483648) p = longint'($signed($urandom));
         end
         ta = ta + tstep;
         if (ta > 32767) ta = 32767;
         if (ta < -32768) ta = -32768;
      end
   endtask

   task automatic random_convert();
      int k;
      longint qp, qt;
      k = $urandom_range(0, ptci_pkg::DEPTH - 1);
      qp = ($urandom_range(1) == 0) ? longint'($signed(16'($urandom)))
            : cal_padc[k] + $urandom_range(0, 600) - 300;
      qt = ($urandom_range(1) == 0) ? longint'($signed(16'($urandom)))
            : cal_tadc[(k / ptci_pkg::POINTS_PER_ROW) * ptci_pkg::POINTS_PER_ROW]
               + $urandom_range(0, 600) - 300;
      if (qp > 32767) qp = 32767;
      if (qp < -32768) qp = -32768;
      if (qt > 32767) qt = 32767;
      if (qt < -32768) qt = -32768;
      convert(qp, qt);
   endtask

   task automatic test_defaults();
      load_table(0);
      convert(-32768, -32768);
      convert(32767, 32767);
      convert(0, 0);
      convert(cal_padc[3], cal_tadc[8]);
   endtask

   task automatic test_special_cases();
      // clipped rows, zero step and dropped stores
      store_point(0, 0, 64'sd2147483647, 0, -100);
      store_point(0, 1, -64'sd2147483648, 1, -100);
      store_point(1, 0, 5, 7, 100);
      store_point(1, 1, 900, 7, 100);
      store_point(3, 0, 1, 1, 1);
      convert(-32768, 0);
      convert(32767, 32767);
      convert(7, -32768);
      set_config(4'd2, 4'd3);
      store_point(0, 3, 1, 1, 1);
      store_point(2, 0, 1, 1, 1);
      convert(20000, 50);
   endtask

   task automatic test_config_sweep();
      logic [3:0] rr [6] = '{4'd0, 4'd1, 4'd3, 4'd2, 4'hE, 4'hF};
      logic [3:0] pp [6] = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd15};
      for (int i = 0; i < 6; i++) begin
         set_config(rr[i], pp[i]);
         load_table(i % 2);
         repeat (6) random_convert();
      end
   endtask

   task automatic test_backpressure();
      set_config(4'd3, 4'd8);
      hold_req++;
      repeat (12) random_convert();
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 800) begin
         set_config($urandom_range(0, 15), $urandom_range(0, 15));
         load_table($urandom_range(0, 2) == 0);
         quiet = (sent == 0) || ($urandom_range(0, 5) == 0);
         sent += 24;
         repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(9) == 0) begin
               store_point($urandom_range(0, 3), $urandom_range(0, 7),
                  longint'($signed($urandom)), longint'($signed(16'($urandom))),
                  longint'($signed(16'($urandom))));
            end else begin
               random_convert();
            end
            sent++;
         end
         quiet = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      ptci_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pressures.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            e = pending_pressures.pop_front();
            if (rsp_data.pressure !== e.pressure || rsp_data.saturated !== e.saturated) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: pressure exp %0d got %0d, saturated exp %b got %b",
                     e.pressure, rsp_data.pressure, e.saturated, rsp_data.saturated);
            end
         end
      end
      if (hold_ack != hold_req) begin
         hold_ack = hold_req;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 10);
      end
   end

   initial begin
      #20000000;
      $display("pressure_temp_calib_interp_tb: done, errors");
      $finish;
   end

   initial begin
      for (int i = 0; i < ptci_pkg::DEPTH; i++) begin
         pt_press[i] = 0;
         cal_padc[i] = 0;
         cal_tadc[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_special_cases();
      test_config_sweep();
      test_backpressure();
      test_random();
      wait_idle();
      if (errors == 0) begin
         $display("pressure_temp_calib_interp_tb: done, clean");
      end else begin
         $display("pressure_temp_calib_interp_tb: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
